[rtl/ubqp_pkg.sv]
// ----------------------------------------------------------------------------
// ubqp_pkg
// shared types and constants for the uart byte queue pair
// ----------------------------------------------------------------------------
`default_nettype none

package ubqp_pkg;

    localparam int TX_DEPTH = 512;
    localparam int RX_DEPTH = 64;
    localparam int TX_AW    = $clog2(TX_DEPTH);
    localparam int RX_AW    = $clog2(RX_DEPTH);

    typedef enum logic [1:0] {
        ACT_TX_QUEUE = 2'd0,
        ACT_TX_READY = 2'd1,
        ACT_RX_PUSH  = 2'd2,
        ACT_RX_READ  = 2'd3
    } act_t;

    typedef enum logic [1:0] {
        RES_OK       = 2'd0,
        RES_TX_FULL  = 2'd1,
        RES_RX_EMPTY = 2'd2,
        RES_RX_DROP  = 2'd3
    } res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic take;
        logic exec;
        logic tx_push;
        logic tx_pop;
        logic tx_bypass;
        logic idle_set;
        logic idle_clr;
        logic rx_push;
        logic rx_pop;
        res_t res;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        act_t act;
        logic tx_idle;
        logic tx_full;
        logic tx_empty;
        logic rx_full;
        logic rx_empty;
        logic out_busy;
    } stat_t;

endpackage

`default_nettype wire

[rtl/ubqp_ctrl.sv]
// ----------------------------------------------------------------------------
// ubqp_ctrl
// sequencer: takes an item, decides the queue operation, loads the result
// ----------------------------------------------------------------------------
`default_nettype none

module ubqp_ctrl (
    input  wire            clk,
    input  wire            rst_n,
    input  ubqp_pkg::stat_t stat,
    output ubqp_pkg::cmd_t  cmd
);
    import ubqp_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res    = RES_OK;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.take = 1'b1;
                if (stat.in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_LOAD;
                case (stat.act)
                    ACT_TX_QUEUE:
                    begin
                        if (stat.tx_idle)
                        begin
                            cmd.tx_bypass = 1'b1;
                            cmd.idle_clr  = 1'b1;
                        end
                        else if (stat.tx_full)
                        begin
                            cmd.res = RES_TX_FULL;
                        end
                        else
                        begin
                            cmd.tx_push = 1'b1;
                        end
                    end
                    ACT_TX_READY:
                    begin
                        if (stat.tx_empty)
                        begin
                            cmd.idle_set = 1'b1;
                        end
                        else
                        begin
                            cmd.tx_pop = 1'b1;
                        end
                    end
                    ACT_RX_PUSH:
                    begin
                        if (stat.rx_full)
                        begin
                            cmd.res = RES_RX_DROP;
                        end
                        else
                        begin
                            cmd.rx_push = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (stat.rx_empty)
                        begin
                            cmd.res = RES_RX_EMPTY;
                        end
                        else
                        begin
                            cmd.rx_pop = 1'b1;
                        end
                    end
                endcase
            end
            ST_LOAD:
            begin
                if (!stat.out_busy)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/ubqp_datapath.sv]
// ----------------------------------------------------------------------------
// ubqp_datapath
// item register, tx and rx ring memories with pointers, result register
// ----------------------------------------------------------------------------
`default_nettype none

module ubqp_datapath (
    input  wire              clk,
    input  wire              rst_n,
    input  ubqp_pkg::cmd_t   cmd,
    output ubqp_pkg::stat_t  stat,
    input  wire              in_valid,
    input  wire [1:0]        in_act,
    input  wire [7:0]        in_data,
    output logic             m_valid,
    input  wire              m_ready,
    output logic [2:0]       m_user,
    output logic [23:0]      m_data
);
    import ubqp_pkg::*;

    function automatic logic [TX_AW-1:0] tx_inc(input logic [TX_AW-1:0] p);
        tx_inc = (p == TX_AW'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [RX_AW-1:0] rx_inc(input logic [RX_AW-1:0] p);
        rx_inc = (p == RX_AW'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    logic [7:0]       tx_mem [TX_DEPTH];
    logic [7:0]       rx_mem [RX_DEPTH];

    act_t             act_reg;
    logic [7:0]       data_reg;
    logic [TX_AW-1:0] tx_wp_reg;
    logic [TX_AW-1:0] tx_rp_reg;
    logic [RX_AW-1:0] rx_wp_reg;
    logic [RX_AW-1:0] rx_rp_reg;
    logic             tx_idle_reg;
    logic [7:0]       tx_rdata_reg;
    logic [7:0]       rx_rdata_reg;
    res_t             res_reg;
    logic             bypass_reg;
    logic             tx_pop_reg;
    logic             rx_pop_reg;
    logic             m_valid_reg;
    logic [2:0]       m_user_reg;
    logic [23:0]      m_data_reg;
    logic [7:0]       send_byte;
    logic [7:0]       read_byte;

    always_comb
    begin
        stat.in_valid = in_valid;
        stat.act      = act_reg;
        stat.tx_idle  = tx_idle_reg;
        stat.tx_full  = (tx_inc(tx_wp_reg) == tx_rp_reg);
        stat.tx_empty = (tx_wp_reg == tx_rp_reg);
        stat.rx_full  = (rx_inc(rx_wp_reg) == rx_rp_reg);
        stat.rx_empty = (rx_wp_reg == rx_rp_reg);
        stat.out_busy = m_valid_reg && !m_ready;
    end

    // item capture and pending result selection
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            act_reg  <= act_t'(in_act);
            data_reg <= in_data;
        end
        if (cmd.exec)
        begin
            res_reg    <= cmd.res;
            bypass_reg <= cmd.tx_bypass;
            tx_pop_reg <= cmd.tx_pop;
            rx_pop_reg <= cmd.rx_pop;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_wp_reg   <= '0;
            tx_rp_reg   <= '0;
            rx_wp_reg   <= '0;
            rx_rp_reg   <= '0;
            tx_idle_reg <= 1'b1;
        end
        else
        begin
            if (cmd.tx_push)
            begin
                tx_wp_reg <= tx_inc(tx_wp_reg);
            end
            if (cmd.tx_pop)
            begin
                tx_rp_reg <= tx_inc(tx_rp_reg);
            end
            if (cmd.rx_push)
            begin
                rx_wp_reg <= rx_inc(rx_wp_reg);
            end
            if (cmd.rx_pop)
            begin
                rx_rp_reg <= rx_inc(rx_rp_reg);
            end
            if (cmd.idle_set)
            begin
                tx_idle_reg <= 1'b1;
            end
            else if (cmd.idle_clr)
            begin
                tx_idle_reg <= 1'b0;
            end
        end
    end

    // ring memories
    always_ff @(posedge clk)
    begin
        if (cmd.tx_push)
        begin
            tx_mem[tx_wp_reg] <= data_reg;
        end
        if (cmd.tx_pop)
        begin
            tx_rdata_reg <= tx_mem[tx_rp_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rx_push)
        begin
            rx_mem[rx_wp_reg] <= data_reg;
        end
        if (cmd.rx_pop)
        begin
            rx_rdata_reg <= rx_mem[rx_rp_reg];
        end
    end

    // result register
    always_comb
    begin
        send_byte = 8'd0;
        if (bypass_reg)
        begin
            send_byte = data_reg;
        end
        else if (tx_pop_reg)
        begin
            send_byte = tx_rdata_reg;
        end
        read_byte = rx_pop_reg ? rx_rdata_reg : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_ready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            m_user_reg <= {bypass_reg | tx_pop_reg, res_reg};
            m_data_reg <= {7'd0, tx_idle_reg, read_byte, send_byte};
        end
    end

    assign m_valid = m_valid_reg;
    assign m_user  = m_user_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

[rtl/uart_byte_queue_pair_unit.sv]
// an item is registered, then the queue step runs, then the result loads once the output is not stalled
// one item at a time (take, queue step with memory access, result load); the next take follows the load
// the result register holds a finished result while the next item is taken
// reset: asynchronous active low, clears pointers, sets the transmitter idle flag
// ring memory contents are not cleared; each queue holds at most depth minus one bytes
// ----------------------------------------------------------------------------
// uart_byte_queue_pair_unit
// tx and rx byte ring queues with transmitter bypass, one action per transfer
// ----------------------------------------------------------------------------
`default_nettype none

module uart_byte_queue_pair_unit (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [7:0]   s_axis_tdata,   // data[7:0]
    input  wire [1:0]   s_axis_tuser,   // action[1:0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata,   // send_byte[7:0], read_byte[15:8], tx_idle_now[16]
    output logic [2:0]  m_axis_tuser    // status[1:0], send_valid[2]
);
    import ubqp_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    ubqp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    ubqp_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .in_valid (s_axis_tvalid),
        .in_act   (s_axis_tuser),
        .in_data  (s_axis_tdata),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_user   (m_axis_tuser),
        .m_data   (m_axis_tdata)
    );

    // an item is captured only when the sequencer is waiting and the source offers one
    always_comb
    begin
        s_axis_tready = cmd.take;
    end

endmodule

`default_nettype wire

[rtl/ubqp_checker.sv]
// ----------------------------------------------------------------------------
// ubqp_checker
// port level checks on the uart byte queue pair results
// ----------------------------------------------------------------------------
`default_nettype none

module ubqp_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [23:0] m_axis_tdata,
    input wire [2:0]  m_axis_tuser
);
    import ubqp_pkg::*;

    // a byte handed to the transmitter always leaves it busy
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> !m_axis_tdata[16])
        else $error("send with transmitter idle");

    // a refused tx byte means the transmitter was busy and nothing moved
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[1:0] == RES_TX_FULL)
        |-> !m_axis_tuser[2] && !m_axis_tdata[16] && (m_axis_tdata[15:8] == 8'd0))
        else $error("tx full result inconsistent");

    // unused byte fields read as zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[2] |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("send byte without send valid");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[15:8] != 8'd0)
        |-> (m_axis_tuser[1:0] == RES_OK) && !m_axis_tuser[2])
        else $error("read byte on a non read result");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

endmodule

bind uart_byte_queue_pair_unit ubqp_checker u_ubqp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

[test/uart_byte_queue_pair_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_byte_queue_pair_unit_test
// feeds directed and random tx/rx queue actions in bursts against a stalling
// output, predicts every result with a behavioral model of both byte rings
// and checks each output transfer in order, field by field
// ----------------------------------------------------------------------------

module uart_byte_queue_pair_unit_test;

    import ubqp_pkg::*;

    localparam int STUCK_LIMIT  = 5000;
    localparam int RANDOM_COUNT = 30;
    localparam int LONG_HOLD    = 400;

    typedef struct {
        act_t       act;
        logic [7:0] data;
    } queue_action_t;

    typedef struct {
        res_t       status;
        logic       send_valid;
        logic [7:0] send_byte;
        logic [7:0] read_byte;
        logic       tx_idle_now;
    } queue_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data = 8'h00;
    logic [1:0]  s_action = 2'b00;
    logic        m_ready = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [23:0] m_data;
    logic [2:0]  m_user;

    uart_byte_queue_pair_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),     // data[7:0]
        .s_axis_tuser  (s_action),   // action[1:0]
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),     // send_byte[7:0], read_byte[15:8], tx_idle_now[16]
        .m_axis_tuser  (m_user)      // status[1:0], send_valid[2]
    );

    // model state of both rings
    logic [7:0]       tx_ring [TX_DEPTH];
    logic [7:0]       rx_ring [RX_DEPTH];
    logic [TX_AW-1:0] tx_wr = '0;
    logic [TX_AW-1:0] tx_rd = '0;
    logic [RX_AW-1:0] rx_wr = '0;
    logic [RX_AW-1:0] rx_rd = '0;
    logic             tx_idle = 1'b1;

    queue_action_t pending_actions[$];
    queue_result_t pending_results[$];

    logic          in_taken = 1'b0;
    int            errors = 0;
    int            results_seen = 0;
    int            stuck_cycles = 0;
    int            burst_left = 0;
    int            gap_left = 0;
    int            rx_cycle = 0;
    int            hold_left = 0;
    logic          long_hold_done = 1'b0;
    queue_result_t want;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic queue_result_t step_queue_pair(act_t act, logic [7:0] data);
        queue_result_t    r;
        logic [TX_AW-1:0] tx_nxt;
        logic [RX_AW-1:0] rx_nxt;
        r = '{RES_OK, 1'b0, 8'h00, 8'h00, 1'b0};
        tx_nxt = tx_wr + 1'b1;
        rx_nxt = rx_wr + 1'b1;
        case (act)
            ACT_TX_QUEUE:
            begin
                if (tx_idle)
                begin
                    r.send_valid = 1'b1;
                    r.send_byte  = data;
                    tx_idle      = 1'b0;
                end
                else if (tx_nxt == tx_rd)
                    r.status = RES_TX_FULL;
                else
                begin
                    tx_ring[tx_wr] = data;
                    tx_wr = tx_nxt;
                end
            end
            ACT_TX_READY:
            begin
                if (tx_wr == tx_rd)
                    tx_idle = 1'b1;
                else
                begin
                    r.send_valid = 1'b1;
                    r.send_byte  = tx_ring[tx_rd];
                    tx_rd = tx_rd + 1'b1;
                end
            end
            ACT_RX_PUSH:
            begin
                if (rx_nxt == rx_rd)
                    r.status = RES_RX_DROP;
                else
                begin
                    rx_ring[rx_wr] = data;
                    rx_wr = rx_nxt;
                end
            end
            default:
            begin
                if (rx_wr == rx_rd)
                    r.status = RES_RX_EMPTY;
                else
                begin
                    r.read_byte = rx_ring[rx_rd];
                    rx_rd = rx_rd + 1'b1;
                end
            end
        endcase
        r.tx_idle_now = tx_idle;
        return r;
    endfunction

    task automatic add_action(act_t act, logic [7:0] data);
        queue_action_t a;
        a.act  = act;
        a.data = data;
        pending_actions.push_back(a);
    endtask

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic add_random_actions(int count);
        int added;
        int n;
        added = 0;
        while (added < count)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    n = $urandom_range(5, 30);
                    repeat (n) add_action(act_t'($urandom_range(0, 3)), any_byte());
                end
                1:
                begin
                    n = $urandom_range(1, 30);
                    repeat (n) add_action(ACT_TX_QUEUE, any_byte());
                    added += n;
                    n = $urandom_range(1, 35);
                    repeat (n) add_action(ACT_TX_READY, any_byte());
                end
                default:
                begin
                    n = $urandom_range(10, 80);
                    repeat (n) add_action(ACT_RX_PUSH, any_byte());
                    added += n;
                    n = $urandom_range(5, 80);
                    repeat (n) add_action(ACT_RX_READ, any_byte());
                end
            endcase
            added += n;
        end
    endtask

    task automatic check_field(string field, logic [7:0] exp_val, logic [7:0] got_val);
        if (exp_val !== got_val)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field,
                     exp_val, got_val);
            errors++;
        end
    endtask

    // driver: bursts of transfers with random gaps
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_taken)
                pending_actions.delete(0);
            if (s_valid && !in_taken)
            begin
                // hold the offered item until it is taken
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                s_valid <= 1'b0;
            end
            else if (pending_actions.size() > 0)
            begin
                s_valid  <= 1'b1;
                s_data   <= pending_actions[0].data;
                s_action <= pending_actions[0].act;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left--;
            end
            else
                s_valid <= 1'b0;
        end
    end

    // receiver: rotating stall patterns plus one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            rx_cycle++;
            if (!long_hold_done && results_seen >= 200)
            begin
                hold_left      = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_ready <= 1'b0;
            end
            else
            begin
                case (rx_cycle[7:6])
                    2'd0:    m_ready <= 1'b1;
                    2'd1:    m_ready <= 1'($urandom_range(0, 1));
                    2'd2:    m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // monitor: check output transfers, then predict for the input transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_valid && m_ready)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h/%h", $time,
                             m_user, m_data);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("status", 8'(want.status), 8'(m_user[1:0]));
                    check_field("send_valid", 8'(want.send_valid), 8'(m_user[2]));
                    check_field("send_byte", want.send_byte, m_data[7:0]);
                    check_field("read_byte", want.read_byte, m_data[15:8]);
                    check_field("tx_idle_now", 8'(want.tx_idle_now), 8'(m_data[16]));
                end
            end
            if (s_valid && s_ready)
                pending_results.push_back(step_queue_pair(act_t'(s_action), s_data));
            in_taken <= s_valid && s_ready;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("** uart_byte_queue_pair_unit: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        // directed: empty read, idle ready, bypass, queued sends, rx round trip
        add_action(ACT_RX_READ, 8'hff);
        add_action(ACT_TX_READY, 8'ha5);
        add_action(ACT_TX_QUEUE, 8'h00);
        add_action(ACT_TX_QUEUE, 8'hff);
        add_action(ACT_TX_QUEUE, 8'h5a);
        add_action(ACT_TX_READY, 8'h00);
        add_action(ACT_TX_READY, 8'hff);
        add_action(ACT_TX_READY, 8'h3c);
        add_action(ACT_TX_READY, 8'hc3);
        add_action(ACT_TX_QUEUE, 8'h81);
        add_action(ACT_TX_READY, 8'h00);
        add_action(ACT_RX_PUSH, 8'h00);
        add_action(ACT_RX_PUSH, 8'hff);
        add_action(ACT_RX_PUSH, 8'h81);
        add_action(ACT_RX_READ, 8'h00);
        add_action(ACT_RX_READ, 8'hff);
        add_action(ACT_RX_READ, 8'h7e);
        add_action(ACT_RX_READ, 8'h55);

        add_random_actions(RANDOM_COUNT);

        // fill the tx ring up to a refused byte, then send a few
        add_action(ACT_TX_READY, any_byte());
        repeat (TX_DEPTH + 1) add_action(ACT_TX_QUEUE, any_byte());
        repeat (8) add_action(ACT_TX_READY, any_byte());
        // fill the rx ring up to a dropped byte, then drain it past empty
        repeat (RX_DEPTH) add_action(ACT_RX_PUSH, any_byte());
        repeat (RX_DEPTH) add_action(ACT_RX_READ, any_byte());

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_actions.size() > 0 || pending_results.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (errors == 0)
            $display("** uart_byte_queue_pair_unit: PASSED **");
        else
            $display("** uart_byte_queue_pair_unit: FAILED **");
        $finish;
    end

endmodule
